// ===== hw/rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the signed decimal formatter
// Widths, character codes and the control word that drives the digit cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  // input and output field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned ChW    = 6;

  // number of decimal digit cells, enough for 2147483648
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;

  // width of the bit counter used during conversion
  localparam int unsigned BitCntW = $clog2(ValueW);
  // width of the remaining-digit counter
  localparam int unsigned RemW    = $clog2(NumDigits + 1);

  // character codes
  localparam logic [ChW-1:0] ChMinus = 6'd45;
  localparam logic [ChW-1:0] ChZero  = 6'd48;

  // control word broadcast to every digit cell
  typedef struct packed {
    logic clear;      // reset the digit to zero
    logic bit_shift;  // add-3 correction then shift one binary bit in
    logic dig_shift;  // take the digit of the lower neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdf_cell.sv =====
// ----------------------------------------------------------------------------
// sdf_cell: one BCD digit cell of the conversion chain
// Holds one decimal digit; shifts binary bits up the chain with add-3
// correction, or passes whole digits toward the most significant cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_cell
  import sdf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic              bit_i,
  input  wire logic [DigitW-1:0] digit_i,
  output logic                   bit_o,
  output logic [DigitW-1:0]      digit_o
);

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] adj;

  // add-3 correction so the shift keeps the digit in decimal range
  always_comb begin
    adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  end

  assign bit_o   = adj[DigitW-1];
  assign digit_o = digit_q;

  // next digit value
  always_comb begin
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.bit_shift) begin
      digit_d = {adj[DigitW-2:0], bit_i};
    end else if (ctrl_i.dig_shift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/signed_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_formatter: 32-bit signed integer to ASCII decimal text
// A chain of BCD digit cells converts the magnitude by shift and add-3,
// then the chain shifts digits out most significant first.
// ----------------------------------------------------------------------------
//  channel  | ports                     | handshake
//  ---------+---------------------------+-----------------------------------
//  command  | start, busy, value_i      | taken when start high and busy low
//  result   | valid_o, ch_o, last_o     | one word per valid_o cycle, no stall
//
//  An item shifts all 32 bits into the digit chain, then issues a '-' word
//  when negative, then shifts the 10 digits out (leading zeros are dropped
//  without a word). busy is high from the cycle after accept until the last
//  digit is registered; it is already low when that word is on valid_o.
//  Reset clears the control state; the result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_formatter
  import sdf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] value_i,
  output logic                   valid_o,
  output logic [ChW-1:0]         ch_o,
  output logic                   last_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StConv   = 2'd1;
  localparam logic [1:0] StDigits = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [ValueW-1:0]  mag_q, mag_d;
  logic               neg_q, neg_d;
  logic               seen_q, seen_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic               valid_q, valid_d;
  logic [ChW-1:0]     ch_q, ch_d;
  logic               last_q, last_d;

  cell_ctrl_t         ctrl;
  logic               accept;
  logic [NumDigits-1:0] bit_link;
  logic [DigitW-1:0]  digit [NumDigits];
  logic [DigitW-1:0]  top_digit;

  assign accept    = start && (state_q == StIdle);
  assign busy      = (state_q != StIdle);
  assign top_digit = digit[NumDigits-1];
  assign bit_link[0] = mag_q[ValueW-1];

  // digit cell chain
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    logic [DigitW-1:0] dig_in;
    if (i == 0) begin : g_low
      assign dig_in = '0;
    end else begin : g_mid
      assign dig_in = digit[i-1];
    end
    if (i == NumDigits - 1) begin : g_top
      sdf_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .bit_i   (bit_link[i]),
        .digit_i (dig_in),
        .bit_o   (),
        .digit_o (digit[i])
      );
    end else begin : g_link
      sdf_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .bit_i   (bit_link[i]),
        .digit_i (dig_in),
        .bit_o   (bit_link[i+1]),
        .digit_o (digit[i])
      );
    end
  end

  // sequencer: convert, then emit sign and digits
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    bit_cnt_d = bit_cnt_q;
    rem_d     = rem_q;
    valid_d   = 1'b0;
    ch_d      = ch_q;
    last_d    = 1'b0;
    ctrl      = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d     = value_i[ValueW-1];
          mag_d     = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;
          bit_cnt_d = '0;
          seen_d    = 1'b0;
          ctrl.clear = 1'b1;
          state_d   = StConv;
        end
      end
      StConv: begin
        ctrl.bit_shift = 1'b1;
        mag_d     = {mag_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitCntW'(ValueW - 1)) begin
          rem_d   = RemW'(NumDigits);
          state_d = StDigits;
        end
      end
      StDigits: begin
        if (neg_q) begin
          // sign word first
          valid_d = 1'b1;
          ch_d    = ChMinus;
          neg_d   = 1'b0;
        end else if (!seen_q && (top_digit == '0) && (rem_q != RemW'(1))) begin
          // drop a leading zero
          ctrl.dig_shift = 1'b1;
          rem_d = rem_q - 1'b1;
        end else begin
          valid_d = 1'b1;
          ch_d    = ChZero + ChW'(top_digit);
          last_d  = (rem_q == RemW'(1));
          seen_d  = 1'b1;
          ctrl.dig_shift = 1'b1;
          rem_d = rem_q - 1'b1;
          if (rem_q == RemW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bit_cnt_q <= bit_cnt_d;
    rem_q     <= rem_d;
    ch_q      <= ch_d;
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sdf_checker.sv =====
// ----------------------------------------------------------------------------
// sdf_checker: port-level checks of the signed decimal formatter
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_checker
  import sdf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              valid_o,
  input wire logic [ChW-1:0]    ch_o,
  input wire logic              last_o
);

  // a taken command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted command");

  // every word is a minus sign or a digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((ch_o == ChMinus) || ((ch_o >= ChZero) && (ch_o <= 6'd57))))
    else $error("character out of range");

  // the sign is never the final word
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (ch_o == ChMinus)) |-> !last_o)
    else $error("minus sign flagged as last");

  // no words while idle, apart from the final word that appears as busy drops
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && $past(!busy) && $past(rst_ni)) |-> !valid_o)
    else $error("word issued while idle");

  // last only marks a word
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last without valid");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .ch_o    (ch_o),
  .last_o  (last_o)
);

`default_nettype wire

// ===== tb/sv/signed_decimal_formatter_tb.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_formatter_tb: self-checking bench for the decimal formatter
// Sends signed 32-bit values through the start/busy command port, predicts the
// ASCII text of each value and checks every result word in order of arrival.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_tb;
  import sdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom  = 330;
  localparam int unsigned DrainLimit = 4000;
  localparam int unsigned TailCycles = 60;

  // one expected character word
  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } char_word_t;

  // predicts the text of accepted values and checks the words that come out
  class decimal_text_scoreboard;
    char_word_t  expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // queue the characters of one accepted value, sign first
    function void note_value(input logic [ValueW-1:0] value);
      logic [ValueW-1:0] mag;
      logic [DigitW-1:0] digits[NumDigits];
      int                n_dig;
      char_word_t        w;
      n_dig = 0;
      if (value[ValueW-1]) begin
        w.ch   = ChMinus;
        w.last = 1'b0;
        expected_chars.push_back(w);
        mag = ~value + 1'b1;
      end else begin
        mag = value;
      end
      // digits least significant first, at least one
      do begin
        digits[n_dig] = DigitW'(mag % 10);
        mag = mag / 10;
        n_dig++;
      end while (mag != 0 && n_dig < NumDigits);
      for (int i = n_dig - 1; i >= 0; i--) begin
        w.ch   = ChZero + ChW'(digits[i]);
        w.last = (i == 0);
        expected_chars.push_back(w);
      end
    endfunction

    // compare one result word with the oldest expectation
    task check_char(input logic [ChW-1:0] ch, input logic last);
      char_word_t w;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word ch=%0d last=%0b", ch, last));
      end else begin
        w = expected_chars.pop_front();
        if (ch !== w.ch)
          report_mismatch($sformatf("ch got %0d want %0d", ch, w.ch));
        if (last !== w.last)
          report_mismatch($sformatf("last got %0b want %0b", last, w.last));
      end
    endtask

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] value_i;
  logic              valid_o;
  logic [ChW-1:0]    ch_o;
  logic              last_o;

  decimal_text_scoreboard text_sb;
  bit                     no_gaps;

  signed_decimal_formatter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .value_i(value_i),
    .valid_o(valid_o),
    .ch_o   (ch_o),
    .last_o (last_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) text_sb.check_char(ch_o, last_o);
  end

  // send one value, called at a falling edge, returns at a falling edge
  task send_value(input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start   = 1'b1;
    value_i = value;
    do @(posedge clk_i); while (busy !== 1'b0);
    text_sb.note_value(value);
    @(negedge clk_i);
  endtask

  // random value shaped toward digit-count and sign boundaries
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] p10;
    int unsigned       k;
    p10 = 1;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: begin
        k = $urandom_range(1, 31);
        v = $urandom() & ((32'h1 << k) - 1);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      2: begin
        k = $urandom_range(0, 9);
        repeat (k) p10 = p10 * 10;
        v = p10 + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      default: begin
        v = {1'b0, {(ValueW-1){1'b1}}} - $urandom_range(0, 15);
        if ($urandom_range(0, 1)) v = ~v;
      end
    endcase
    return v;
  endfunction

  // stimulus and end of run
  initial begin
    logic [ValueW-1:0] directed[$];
    int unsigned       waited;
    text_sb = new();
    no_gaps = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero, single digits, digit-count edges, both extremes
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                 32'd100, -32'sd9, 32'd999_999_999, 32'd1_000_000_000,
                 -32'sd999_999_999, -32'sd1_000_000_000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'd1_234_567_890,
                 -32'sd1_234_567_890, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (directed[i]) send_value(directed[i]);

    // random values, with stretches of back-to-back values
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_value(pick_value());
    end
    start = 1'b0;

    // drain outstanding words then watch for strays
    waited = 0;
    while (text_sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (text_sb.pending() != 0)
      text_sb.report_mismatch($sformatf("%0d words never arrived", text_sb.pending()));

    if (text_sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_cell.sv
hw/rtl/signed_decimal_formatter.sv
hw/rtl/sdf_checker.sv
tb/sv/signed_decimal_formatter_tb.sv
